[design/i2ctbe_pkg.sv]
package i2ctbe_pkg;

    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int EV_W   = 3;

    localparam logic [CNT_W-1:0] ADDR_BITS = 4'd7;
    localparam logic [CNT_W-1:0] DATA_BITS = 4'd8;
    localparam logic [CNT_W-1:0] TX_BITS   = 4'd9;

    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_START    = 3'd1;
    localparam logic [EV_W-1:0] EV_MATCH    = 3'd2;
    localparam logic [EV_W-1:0] EV_MISMATCH = 3'd3;
    localparam logic [EV_W-1:0] EV_STOP     = 3'd4;
    localparam logic [EV_W-1:0] EV_ACK      = 3'd5;
    localparam logic [EV_W-1:0] EV_NACK     = 3'd6;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_ADDRESS   = 8'b0000_0010,
        PH_RW        = 8'b0000_0100,
        PH_ACK_START = 8'b0000_1000,
        PH_ACK_END   = 8'b0001_0000,
        PH_DATA      = 8'b0010_0000,
        PH_CHECK_ACK = 8'b0100_0000,
        PH_WAIT_STOP = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic              scl_line;
        logic              sda_line;
        logic              tx_available;
        logic [BYTE_W-1:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic              sda_pull_low;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_take;
        logic [EV_W-1:0]   bus_event;
    } out_item_t;

endpackage

[design/i2c_target_bit_engine_top.sv]
// An accepted input item is held in the input register, and its result item is then
// captured in the result register. Throughput: one item per cycle while out_ready does
// not stall it; the line state advances once per sample, between the two registers.
// Reset: rst_n clears the line state to idle with SDA released, both previous
// line samples high, own_address zero, and both pipeline registers empty.
module i2c_target_bit_engine_top
    import i2ctbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data
);

    logic      stage_valid;
    logic      stage_ready;
    in_item_t  stage_data;
    out_item_t result;

    i2ctbe_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_data  (stage_data)
    );

    i2ctbe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (stage_valid && stage_ready),
        .item        (stage_data),
        .result      (result)
    );

    i2ctbe_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_data  (result),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

[design/i2ctbe_in_stage.sv]
module i2ctbe_in_stage
    import i2ctbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     stage_valid,
    input  logic     stage_ready,
    output in_item_t stage_data
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // The register can take a new item whenever it is empty or draining.
    assign in_ready   = !valid_reg || stage_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

[design/i2ctbe_core.sv]
module i2ctbe_core
    import i2ctbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              step,
    input  in_item_t          item,
    output out_item_t         result
);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [ADDR_W-1:0] addr_shift_reg, addr_shift_next;
    logic [BYTE_W-1:0] data_shift_reg, data_shift_next;
    logic              to_master_reg, to_master_next;
    logic              prev_scl_reg;
    logic              prev_sda_reg;
    logic              sda_drive_reg, sda_drive_next;
    logic [ADDR_W-1:0] own_address_reg;

    logic              scl_rise, scl_fall, sda_fall, stop_seen;
    logic              tx_edge;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              take;
    logic [EV_W-1:0]   ev;
    logic [CNT_W-1:0]  bit_pos;

    assign scl_rise  = !prev_scl_reg && item.scl_line;
    assign scl_fall  = prev_scl_reg && !item.scl_line;
    assign sda_fall  = prev_sda_reg && !item.sda_line;
    assign stop_seen = !prev_sda_reg && item.sda_line && prev_scl_reg && item.scl_line;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        addr_shift_next = addr_shift_reg;
        data_shift_next = data_shift_reg;
        to_master_next  = to_master_reg;
        sda_drive_next  = sda_drive_reg;
        rx_valid        = 1'b0;
        rx_byte         = '0;
        take            = 1'b0;
        ev              = EV_NONE;
        tx_edge         = 1'b0;
        bit_pos         = '0;

        unique case (phase_reg)
            PH_ADDRESS:
            begin
                if (scl_rise)
                begin
                    addr_shift_next = {addr_shift_reg[ADDR_W-2:0], item.sda_line};
                    bit_count_next  = bit_count_reg + 1'b1;
                    if (bit_count_next >= ADDR_BITS)
                    begin
                        bit_count_next = '0;
                        if (addr_shift_next == own_address_reg)
                        begin
                            ev         = EV_MATCH;
                            phase_next = PH_RW;
                        end
                        else
                        begin
                            ev             = EV_MISMATCH;
                            phase_next     = PH_IDLE;
                            sda_drive_next = 1'b0;
                        end
                    end
                end
            end
            PH_RW:
            begin
                if (scl_rise)
                begin
                    to_master_next = item.sda_line;
                    phase_next     = PH_ACK_START;
                end
            end
            PH_ACK_START:
            begin
                if (scl_fall)
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = PH_ACK_END;
                end
            end
            PH_ACK_END:
            begin
                if (scl_fall)
                begin
                    sda_drive_next = 1'b0;
                    phase_next     = PH_DATA;
                    bit_count_next = '0;
                    // In transmit mode the same falling edge sets up the first bit.
                    tx_edge        = to_master_reg;
                end
            end
            PH_DATA:
            begin
                if (to_master_reg)
                begin
                    tx_edge = scl_fall;
                end
                else if (bit_count_reg == 4'd1 && stop_seen)
                begin
                    ev             = EV_STOP;
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                    sda_drive_next = 1'b0;
                end
                else if (scl_rise)
                begin
                    data_shift_next = {data_shift_reg[BYTE_W-2:0], item.sda_line};
                    bit_count_next  = bit_count_reg + 1'b1;
                    if (bit_count_next >= DATA_BITS)
                    begin
                        rx_valid       = 1'b1;
                        rx_byte        = data_shift_next;
                        bit_count_next = '0;
                        phase_next     = PH_ACK_START;
                    end
                end
            end
            PH_CHECK_ACK:
            begin
                if (scl_rise)
                begin
                    if (item.sda_line)
                    begin
                        ev         = EV_NACK;
                        phase_next = PH_WAIT_STOP;
                    end
                    else
                    begin
                        ev             = EV_ACK;
                        phase_next     = PH_DATA;
                        bit_count_next = '0;
                    end
                end
            end
            PH_WAIT_STOP:
            begin
                if (stop_seen)
                begin
                    ev             = EV_STOP;
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                end
            end
            default:
            begin
                if (sda_fall && item.scl_line)
                begin
                    ev              = EV_START;
                    phase_next      = PH_ADDRESS;
                    bit_count_next  = '0;
                    addr_shift_next = '0;
                    sda_drive_next  = 1'b0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase

        if (tx_edge)
        begin
            if (bit_count_next == '0 && !item.tx_available)
            begin
                // Nothing queued at a byte start: let go of the bus.
                sda_drive_next = 1'b0;
                phase_next     = PH_IDLE;
            end
            else
            begin
                if (bit_count_next == '0)
                begin
                    data_shift_next = item.tx_byte;
                    take            = 1'b1;
                end
                bit_count_next = bit_count_next + 1'b1;
                if (bit_count_next >= TX_BITS)
                begin
                    bit_count_next = '0;
                    sda_drive_next = 1'b0;
                    phase_next     = PH_CHECK_ACK;
                end
                else
                begin
                    bit_pos        = DATA_BITS - bit_count_next;
                    sda_drive_next = !data_shift_next[bit_pos[2:0]];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_address_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            addr_shift_reg <= '0;
            data_shift_reg <= '0;
            to_master_reg  <= 1'b0;
            prev_scl_reg   <= 1'b1;
            prev_sda_reg   <= 1'b1;
            sda_drive_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            addr_shift_reg <= addr_shift_next;
            data_shift_reg <= data_shift_next;
            to_master_reg  <= to_master_next;
            prev_scl_reg   <= item.scl_line;
            prev_sda_reg   <= item.sda_line;
            sda_drive_reg  <= sda_drive_next;
        end
    end

    assign result.sda_pull_low = sda_drive_next;
    assign result.rx_valid     = rx_valid;
    assign result.rx_byte      = rx_byte;
    assign result.tx_take      = take;
    assign result.bus_event    = ev;

endmodule

[design/i2ctbe_out_stage.sv]
module i2ctbe_out_stage
    import i2ctbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      stage_valid,
    output logic      stage_ready,
    input  out_item_t stage_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign stage_ready = !valid_reg || out_ready;
    assign valid_next  = stage_ready ? stage_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid && stage_ready)
        begin
            data_reg <= stage_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/i2ctbe_checker.sv]
module i2ctbe_checker
    import i2ctbe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input out_item_t         out_data
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.rx_valid |-> out_data.rx_byte == '0)
        else $error("rx_byte nonzero without rx_valid");

    // A received byte and a taken transmit byte never carry a bus event,
    // and the two never complete together.
    a_data_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.rx_valid || out_data.tx_take)
            |-> out_data.bus_event == EV_NONE && !(out_data.rx_valid && out_data.tx_take))
        else $error("data strobe together with a bus event");

    // The target never pulls SDA in the item that reports a start or a stop.
    a_release_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.bus_event == EV_START || out_data.bus_event == EV_STOP)
            |-> !out_data.sda_pull_low)
        else $error("SDA pulled low on start or stop");

endmodule

bind i2c_target_bit_engine_top i2ctbe_checker u_i2ctbe_checker (.*);

[test/i2c_target_line_checker.sv]
`timescale 1ns / 1ps

module i2c_target_line_checker
    import i2ctbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_item_t          in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_item_t         out_data,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    output int                mismatch_count,
    output int                pending,
    output int                match_count,
    output int                rx_byte_count,
    output int                take_count,
    output int                nack_count,
    output int                stop_count
);

    // Shadow copy of the target's line state and its address register.
    logic [ADDR_W-1:0] own_addr;
    phase_t            ph;
    logic [CNT_W-1:0]  bit_cnt;
    logic [ADDR_W-1:0] addr_sr;
    logic [BYTE_W-1:0] data_sr;
    logic              to_master;
    logic              prev_scl;
    logic              prev_sda;
    logic              drive;

    out_item_t         expected_response_q[$];

    task automatic note_error(input string msg);
        mismatch_count++;
        $display("[%0t ns] check: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            note_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic out_item_t predict_line_response(input in_item_t s);
        out_item_t  r;
        logic       scl_rise;
        logic       scl_fall;
        logic       sda_fall;
        logic       stop_seen;
        logic       shift_out;
        logic       keep_going;
        logic [2:0] bit_idx;
        r         = '0;
        r.bus_event = EV_NONE;
        scl_rise  = !prev_scl && s.scl_line;
        scl_fall  = prev_scl && !s.scl_line;
        sda_fall  = prev_sda && !s.sda_line;
        stop_seen = !prev_sda && s.sda_line && prev_scl && s.scl_line;
        shift_out = 1'b0;

        case (ph)
            PH_ADDRESS:
                if (scl_rise)
                begin
                    addr_sr = {addr_sr[ADDR_W-2:0], s.sda_line};
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= ADDR_BITS)
                    begin
                        bit_cnt = '0;
                        if (addr_sr == own_addr)
                        begin
                            r.bus_event = EV_MATCH;
                            ph = PH_RW;
                        end
                        else
                        begin
                            r.bus_event = EV_MISMATCH;
                            ph = PH_IDLE;
                            drive = 1'b0;
                        end
                    end
                end
            PH_RW:
                if (scl_rise)
                begin
                    to_master = s.sda_line;
                    ph = PH_ACK_START;
                end
            PH_ACK_START:
                if (scl_fall)
                begin
                    drive = 1'b1;
                    ph = PH_ACK_END;
                end
            PH_ACK_END:
                if (scl_fall)
                begin
                    drive = 1'b0;
                    ph = PH_DATA;
                    bit_cnt = '0;
                    // In a read the falling edge that ends the acknowledge also
                    // puts out the first data bit.
                    shift_out = to_master;
                end
            PH_DATA:
                if (to_master)
                begin
                    shift_out = scl_fall;
                end
                else if (bit_cnt == 4'd1 && stop_seen)
                begin
                    // The clock rise of a stop condition was taken as a data bit.
                    r.bus_event = EV_STOP;
                    ph = PH_IDLE;
                    bit_cnt = '0;
                    drive = 1'b0;
                end
                else if (scl_rise)
                begin
                    data_sr = {data_sr[BYTE_W-2:0], s.sda_line};
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= DATA_BITS)
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = data_sr;
                        bit_cnt = '0;
                        ph = PH_ACK_START;
                    end
                end
            PH_CHECK_ACK:
                if (scl_rise)
                begin
                    if (s.sda_line)
                    begin
                        r.bus_event = EV_NACK;
                        ph = PH_WAIT_STOP;
                    end
                    else
                    begin
                        r.bus_event = EV_ACK;
                        ph = PH_DATA;
                        bit_cnt = '0;
                    end
                end
            PH_WAIT_STOP:
                if (stop_seen)
                begin
                    r.bus_event = EV_STOP;
                    ph = PH_IDLE;
                    bit_cnt = '0;
                end
            default:
                if (sda_fall && s.scl_line)
                begin
                    r.bus_event = EV_START;
                    ph = PH_ADDRESS;
                    bit_cnt = '0;
                    addr_sr = '0;
                    drive = 1'b0;
                end
                else
                begin
                    ph = PH_IDLE;
                end
        endcase

        if (shift_out)
        begin
            keep_going = 1'b1;
            if (bit_cnt == '0)
            begin
                if (!s.tx_available)
                begin
                    // Nothing queued: let go of the bus and wait for a new start.
                    drive = 1'b0;
                    ph = PH_IDLE;
                    keep_going = 1'b0;
                end
                else
                begin
                    data_sr = s.tx_byte;
                    r.tx_take = 1'b1;
                end
            end
            if (keep_going)
            begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt >= TX_BITS)
                begin
                    bit_cnt = '0;
                    drive = 1'b0;
                    ph = PH_CHECK_ACK;
                end
                else
                begin
                    bit_idx = 3'(DATA_BITS - bit_cnt);
                    drive = !data_sr[bit_idx];
                end
            end
        end

        prev_scl = s.scl_line;
        prev_sda = s.sda_line;
        r.sda_pull_low = drive;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            own_addr = '0;
            ph = PH_IDLE;
            bit_cnt = '0;
            addr_sr = '0;
            data_sr = '0;
            to_master = 1'b0;
            prev_scl = 1'b1;
            prev_sda = 1'b1;
            drive = 1'b0;
            expected_response_q.delete();
            mismatch_count = 0;
            match_count = 0;
            rx_byte_count = 0;
            take_count = 0;
            nack_count = 0;
            stop_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                own_addr = cfg_wr_data;
            if (in_valid && in_ready)
                expected_response_q.push_back(predict_line_response(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_response_q.size() == 0)
                begin
                    note_error("result item arrived with nothing expected");
                end
                else
                begin
                    want = expected_response_q.pop_front();
                    check_field("sda_pull_low", 8'(out_data.sda_pull_low),
                                8'(want.sda_pull_low));
                    check_field("rx_valid", 8'(out_data.rx_valid), 8'(want.rx_valid));
                    check_field("rx_byte", out_data.rx_byte, want.rx_byte);
                    check_field("tx_take", 8'(out_data.tx_take), 8'(want.tx_take));
                    check_field("bus_event", 8'(out_data.bus_event), 8'(want.bus_event));
                    if (want.bus_event == EV_MATCH)
                        match_count++;
                    if (want.bus_event == EV_NACK)
                        nack_count++;
                    if (want.bus_event == EV_STOP)
                        stop_count++;
                    if (want.rx_valid)
                        rx_byte_count++;
                    if (want.tx_take)
                        take_count++;
                end
            end
            pending <= expected_response_q.size();
        end
    end

endmodule

[test/tb_i2c_target_bit_engine_top.sv]
`timescale 1ns / 1ps

module tb_i2c_target_bit_engine_top;
    import i2ctbe_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;
    logic              cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;

    int mismatch_count;
    int pending;
    int match_count;
    int rx_byte_count;
    int take_count;
    int nack_count;
    int stop_count;

    int                sent_items;
    int                settings;
    int                gap_pct;
    int                stall_pct;
    int                hold_asks;
    int                tx_avail_pct;
    int                cycle_count;
    logic [ADDR_W-1:0] target_addr;
    logic              line_scl;
    logic              line_sda;

    i2c_target_bit_engine_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    i2c_target_line_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .match_count    (match_count),
        .rx_byte_count  (rx_byte_count),
        .take_count     (take_count),
        .nack_count     (nack_count),
        .stop_count     (stop_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_i2c_target_bit_engine_top: errors");
        $finish;
    end

    // Result side: random stalls, plus a long hold whenever one is asked for.
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_asks)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic offer_sample(input in_item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        line_scl = it.scl_line;
        line_sda = it.sda_line;
        sent_items++;
    endtask

    // One line level, sometimes held for two samples as an oversampler would.
    task automatic put_level(input logic scl, input logic sda);
        in_item_t it;
        int       reps;
        reps = ($urandom_range(3) == 0) ? 2 : 1;
        repeat (reps)
        begin
            it.scl_line     = scl;
            it.sda_line     = sda;
            it.tx_available = ($urandom_range(99) < tx_avail_pct);
            it.tx_byte      = BYTE_W'($urandom);
            offer_sample(it);
        end
    endtask

    task automatic clock_bit(input logic b);
        put_level(1'b0, b);
        put_level(1'b1, b);
        put_level(1'b0, b);
    endtask

    task automatic send_start();
        if (!(line_scl && line_sda))
            put_level(1'b0, 1'b1);
        put_level(1'b1, 1'b1);
        put_level(1'b1, 1'b0);
        put_level(1'b0, 1'b0);
    endtask

    task automatic close_frame();
        put_level(1'b0, 1'b0);
        put_level(1'b1, 1'b0);
        put_level(1'b1, 1'b1);
    endtask

    task automatic run_transfer();
        int                kind;
        int                nbytes;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              rd;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            addr = ($urandom_range(99) < 75) ? target_addr : ADDR_W'($urandom);
            rd = 1'($urandom_range(1));
            tx_avail_pct = rd ? 92 : 50;
            send_start();
            for (int i = ADDR_W - 1; i >= 0; i--)
                clock_bit(addr[i]);
            clock_bit(rd);
            clock_bit(1'b0);
            nbytes = $urandom_range(1, 4);
            for (int n = 0; n < nbytes; n++)
            begin
                data = BYTE_W'($urandom);
                for (int i = BYTE_W - 1; i >= 0; i--)
                    clock_bit(data[i]);
                // The master usually refuses the last byte of a read.
                clock_bit(rd && n == nbytes - 1 && $urandom_range(4) != 0);
            end
            close_frame();
        end
        else if (kind < 90)
        begin
            tx_avail_pct = 50;
            repeat ($urandom_range(1, 12))
                put_level(1'($urandom), 1'($urandom));
        end
        else
        begin
            send_start();
            repeat ($urandom_range(0, 12))
                clock_bit(1'($urandom));
            close_frame();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_own_address(input logic [ADDR_W-1:0] addr);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        target_addr = addr;
        settings++;
    endtask

    task automatic run_random(input int gap, input int stall, input int goal);
        gap_pct = gap;
        stall_pct = stall;
        while (sent_items < goal)
            run_transfer();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_asks    = 0;
        tx_avail_pct = 50;
        sent_items   = 0;
        settings     = 0;
        target_addr  = '0;
        line_scl     = 1'b1;
        line_sda     = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_own_address({ADDR_W{1'b1}});
        // Both lines falling and rising together, then a start and a read from
        // the all-ones address whose first byte is taken on the acknowledge.
        offer_sample(in_item_t'{1'b1, 1'b1, 1'b0, 8'h00});
        offer_sample(in_item_t'{1'b0, 1'b0, 1'b0, 8'h00});
        offer_sample(in_item_t'{1'b1, 1'b1, 1'b1, 8'hFF});
        offer_sample(in_item_t'{1'b1, 1'b0, 1'b1, 8'hFF});
        repeat (ADDR_W + 1)
        begin
            offer_sample(in_item_t'{1'b0, 1'b1, 1'b1, 8'hFF});
            offer_sample(in_item_t'{1'b1, 1'b1, 1'b1, 8'hFF});
        end
        offer_sample(in_item_t'{1'b0, 1'b0, 1'b0, 8'h00});
        offer_sample(in_item_t'{1'b1, 1'b0, 1'b0, 8'h00});
        offer_sample(in_item_t'{1'b0, 1'b0, 1'b1, 8'hA5});
        run_random(0, 0, 380);

        set_own_address('0);
        run_random(52, 0, 760);
        set_own_address(ADDR_W'($urandom));
        run_random(0, 52, 1140);
        set_own_address(ADDR_W'($urandom));
        run_random(10, 10, 1520);

        // Hold the result side off while samples keep coming, so the block
        // fills up and pushes back on its input.
        set_own_address(ADDR_W'($urandom));
        hold_asks = hold_asks + 1;
        run_random(0, 0, 1900);

        wait_drained();
        $display("Ran %0d line samples over %0d addresses with gaps, stalls and a long hold:",
                 sent_items, settings);
        $display("%0d matches, %0d bytes in, %0d out, %0d nacks, %0d stops.",
                 match_count, rx_byte_count, take_count, nack_count, stop_count);
        if (mismatch_count == 0 && pending == 0)
            $display("tb_i2c_target_bit_engine_top: clean");
        else
            $display("tb_i2c_target_bit_engine_top: errors");
        $finish;
    end

endmodule

[files.f]
design/i2ctbe_pkg.sv
design/i2ctbe_in_stage.sv
design/i2ctbe_core.sv
design/i2ctbe_out_stage.sv
design/i2c_target_bit_engine_top.sv
design/i2ctbe_checker.sv
test/i2c_target_line_checker.sv
test/tb_i2c_target_bit_engine_top.sv
